@@ src/apc_pkg.sv @@
package apc_pkg;

  localparam int FIELD_BITS = 16;
  localparam int VALUE_BITS = 16;
  // trial divisors stay at or below the square root, plus one step past it
  localparam int D_BITS     = VALUE_BITS / 2 + 1;
  localparam int SQ_BITS    = 2 * D_BITS;
  // proper divisor sums stay below 8n over the whole range of VALUE_BITS
  localparam int SUM_BITS   = VALUE_BITS + 3;
  localparam int CNT_BITS   = $clog2(VALUE_BITS);

  localparam logic [FIELD_BITS-1:0] LIMIT_RESET = 16'hFFFF;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_START  = 6'b000010,
    S_SQCHK  = 6'b000100,
    S_DIV    = 6'b001000,
    S_ACC    = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

endpackage

@@ src/amicable_pair_checker_core.sv @@
// amicable pair checker
// input channel: in_valid / in_stall carry one candidate; a transfer takes
// place on a rising edge with in_valid high and in_stall low. in_stall is
// high while a candidate is being worked on and low otherwise.
// result channel: out_valid / out_stall carry is_pair and partner, one
// result for every candidate, held in an output register until taken.
// cfg channel: cfg_valid / cfg_ready write search_limit; cfg_ready is
// always high and the limit should only change while the block is idle.
// divider: both divisor sums run on one shared restoring divider that
// yields one quotient bit per cycle, for each trial divisor
// d = 2 .. floor(sqrt(n)); the pass over s runs only when
// candidate < s <= limit. candidates at or above the limit skip the
// divider and go straight to the result state; zero and one skip the
// division steps as well.
// a new candidate is taken as soon as the previous result has been moved
// into the output register, even while the receiver stalls that result.
// reset (rst_n low, synchronous) sets the limit to 65535, drops any work
// in progress and clears the output valid.
module amicable_pair_checker_core import apc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [FIELD_BITS-1:0] in_candidate,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_is_pair,
  output logic [FIELD_BITS-1:0] out_partner,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [FIELD_BITS-1:0] cfg_data
);

  state_t                state_r, state_nxt;
  logic [VALUE_BITS-1:0] limit_r, limit_nxt;
  logic [VALUE_BITS-1:0] cand_r, cand_nxt;
  logic [VALUE_BITS-1:0] n_r, n_nxt;
  logic                  pass_r, pass_nxt;
  logic [SUM_BITS-1:0]   total_r, total_nxt;
  logic [D_BITS-1:0]     d_r, d_nxt;
  logic [VALUE_BITS-1:0] dvd_r, dvd_nxt;
  logic [D_BITS-1:0]     rem_r, rem_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                  pair_r, pair_nxt;
  logic [VALUE_BITS-1:0] s_r, s_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_is_pair_r, out_is_pair_nxt;
  logic [FIELD_BITS-1:0] out_partner_r, out_partner_nxt;

  logic                  in_xfer;
  logic [SQ_BITS-1:0]    d_sq;
  logic [D_BITS:0]       trial;
  logic                  qbit;
  logic [SUM_BITS-1:0]   q_add;
  logic                  out_free;

  assign in_xfer  = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free = !out_valid_r || !out_stall;

  assign d_sq  = SQ_BITS'(d_r) * SQ_BITS'(d_r);
  assign trial = {rem_r, dvd_r[VALUE_BITS-1]};
  assign qbit  = (trial >= {1'b0, d_r});
  // cofactor is added only when it differs from the divisor
  assign q_add = (dvd_r != VALUE_BITS'(d_r)) ? SUM_BITS'(dvd_r) : '0;

  always_comb begin
    state_nxt       = state_r;
    limit_nxt       = limit_r;
    cand_nxt        = cand_r;
    n_nxt           = n_r;
    pass_nxt        = pass_r;
    total_nxt       = total_r;
    d_nxt           = d_r;
    dvd_nxt         = dvd_r;
    rem_nxt         = rem_r;
    cnt_nxt         = cnt_r;
    pair_nxt        = pair_r;
    s_nxt           = s_r;
    out_valid_nxt   = out_valid_r;
    out_is_pair_nxt = out_is_pair_r;
    out_partner_nxt = out_partner_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_valid && cfg_ready) begin
      limit_nxt = VALUE_BITS'(cfg_data);
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cand_nxt = VALUE_BITS'(in_candidate);
          n_nxt    = VALUE_BITS'(in_candidate);
          pass_nxt = 1'b0;
          pair_nxt = 1'b0;
          s_nxt    = '0;
          if (VALUE_BITS'(in_candidate) < limit_r) begin
            state_nxt = S_START;
          end else begin
            state_nxt = S_RESULT;
          end
        end
      end
      S_START: begin
        d_nxt = D_BITS'(2);
        if (n_r < VALUE_BITS'(2)) begin
          total_nxt = '0;
          state_nxt = S_ACC;
          d_nxt     = '0;
        end else begin
          total_nxt = SUM_BITS'(1);
          state_nxt = S_SQCHK;
        end
      end
      S_SQCHK: begin
        if (d_sq <= SQ_BITS'(n_r)) begin
          dvd_nxt   = n_r;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end else begin
          d_nxt     = '0;
          state_nxt = S_ACC;
        end
      end
      S_DIV: begin
        rem_nxt = qbit ? D_BITS'(trial - {1'b0, d_r}) : D_BITS'(trial);
        dvd_nxt = {dvd_r[VALUE_BITS-2:0], qbit};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(VALUE_BITS - 1)) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        // d of zero marks the end of a pass
        if (d_r != '0) begin
          if (rem_r == '0) begin
            total_nxt = total_r + SUM_BITS'(d_r) + q_add;
          end
          d_nxt     = d_r + 1'b1;
          state_nxt = S_SQCHK;
        end else if (!pass_r) begin
          if ((SUM_BITS'(cand_r) < total_r) && (total_r <= SUM_BITS'(limit_r))) begin
            s_nxt     = VALUE_BITS'(total_r);
            n_nxt     = VALUE_BITS'(total_r);
            pass_nxt  = 1'b1;
            state_nxt = S_START;
          end else begin
            state_nxt = S_RESULT;
          end
        end else begin
          pair_nxt  = (total_r == SUM_BITS'(cand_r));
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_is_pair_nxt = pair_r;
          out_partner_nxt = pair_r ? FIELD_BITS'(s_r) : '0;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= VALUE_BITS'(LIMIT_RESET);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r        <= cand_nxt;
    n_r           <= n_nxt;
    pass_r        <= pass_nxt;
    total_r       <= total_nxt;
    d_r           <= d_nxt;
    dvd_r         <= dvd_nxt;
    rem_r         <= rem_nxt;
    cnt_r         <= cnt_nxt;
    pair_r        <= pair_nxt;
    s_r           <= s_nxt;
    out_is_pair_r <= out_is_pair_nxt;
    out_partner_r <= out_partner_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_is_pair = out_is_pair_r;
  assign out_partner = out_partner_r;

endmodule

@@ verif/amicable_pair_checker_core_test.sv @@
`timescale 1ns / 100ps

module amicable_pair_checker_core_test;
  import apc_pkg::*;

  localparam int unsigned RUN_LIMIT   = 4000000;
  localparam int unsigned HOLD_CYCLES = 6000;
  localparam longint unsigned VAL_MASK = (64'd1 << VALUE_BITS) - 64'd1;

  // amicable members (smaller and larger), one pair whose partner overflows
  // 16 bits, and the perfect numbers in range
  localparam int NOTABLE [21] = '{220, 284, 1184, 1210, 2620, 2924, 5020, 5564,
                                  6232, 6368, 10744, 10856, 12285, 14595, 17296,
                                  18416, 63020, 6, 28, 496, 8128};

  typedef struct packed {
    logic                  is_pair;
    logic [FIELD_BITS-1:0] partner;
  } verdict_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [FIELD_BITS-1:0] in_candidate = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_is_pair;
  logic [FIELD_BITS-1:0] out_partner;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [FIELD_BITS-1:0] cfg_data = '0;

  logic [FIELD_BITS-1:0] candidate_queue [$];
  verdict_t              verdict_queue [$];
  logic [FIELD_BITS-1:0] search_limit = LIMIT_RESET;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_go = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int          mismatches = 0;
  int          results_seen = 0;
  int          pairs_seen = 0;
  int          limits_used = 0;

  amicable_pair_checker_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_candidate (in_candidate),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_is_pair  (out_is_pair),
    .out_partner  (out_partner),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sum of all divisors of n below n
  function automatic longint unsigned divisor_total(longint unsigned n);
    longint unsigned total;
    longint unsigned d;
    if (n < 2) return 0;
    total = 1;
    for (d = 2; d * d <= n; d++) begin
      if (n % d == 0) begin
        total += d;
        if (n / d != d) total += n / d;
      end
    end
    return total;
  endfunction

  function automatic verdict_t amicable_verdict(logic [FIELD_BITS-1:0] cand_in,
                                                logic [FIELD_BITS-1:0] lim_in);
    verdict_t        v;
    longint unsigned cand;
    longint unsigned lim;
    longint unsigned s;
    v = '0;
    cand = cand_in & VAL_MASK;
    lim = lim_in & VAL_MASK;
    if (cand < lim) begin
      s = divisor_total(cand);
      // perfect numbers fail cand < s, the larger member fails it too
      if (cand < s && s <= lim && divisor_total(s) == cand) begin
        v.is_pair = 1'b1;
        v.partner = s[FIELD_BITS-1:0];
      end
    end
    return v;
  endfunction

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // driver: offers candidates, predicts the verdict of each transfer
  always @(posedge clk) begin : driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        verdict_queue.push_back(amicable_verdict(in_candidate, search_limit));
      if (!in_valid || !in_stall) begin
        if (candidate_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_candidate <= candidate_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transfer against the oldest verdict
  always @(posedge clk) begin : monitor
    verdict_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_is_pair) pairs_seen++;
        if (verdict_queue.size() == 0) begin
          flag_mismatch("result with nothing pending, partner", out_partner, 0);
        end else begin
          want = verdict_queue.pop_front();
          if (out_is_pair !== want.is_pair)
            flag_mismatch("is_pair", out_is_pair, want.is_pair);
          if (out_partner !== want.partner)
            flag_mismatch("partner", out_partner, want.partner);
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // long receiver hold-off so the block fills up and stalls its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_go && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               verdict_queue.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic set_limit(input logic [FIELD_BITS-1:0] value);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    search_limit <= value;
    limits_used++;
  endtask

  // sampled at the falling edge so the driver's updates have settled
  task automatic wait_drained();
    do @(negedge clk);
    while (!(candidate_queue.size() == 0 && !in_valid && verdict_queue.size() == 0));
  endtask

  task automatic run_random(input logic [FIELD_BITS-1:0] lim, input int n);
    int unsigned           roll;
    logic [FIELD_BITS-1:0] cand;
    set_limit(lim);
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      if (roll < 45)
        cand = FIELD_BITS'($urandom_range(0, 3000));
      else if (roll < 70)
        cand = FIELD_BITS'(NOTABLE[$urandom_range(20)]);
      else if (roll < 80)
        cand = FIELD_BITS'(NOTABLE[$urandom_range(20)] + $urandom_range(2) - 1);
      else if (roll < 90)
        cand = FIELD_BITS'($urandom_range(0, 65535));
      else
        cand = FIELD_BITS'(lim + $urandom_range(2) - 1);
      candidate_queue.push_back(cand);
    end
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct <= 35;
    recv_idle_pct <= 74;
    set_limit(16'hFFFF);
    candidate_queue = '{16'd0, 16'd1, 16'd2, 16'd6, 16'd12, 16'd28, 16'd220, 16'd284,
                        16'd1184, 16'd1210, 16'd8128, 16'd12285, 16'd17296,
                        16'd32768, 16'd63020, 16'd65534, 16'd65535};
    wait_drained();
    // nothing is below a zero limit
    set_limit(16'd0);
    candidate_queue.push_back(16'd220);
    candidate_queue.push_back(16'd65535);
    wait_drained();
    set_limit(16'd1);
    candidate_queue.push_back(16'd0);
    candidate_queue.push_back(16'd1);
    wait_drained();
    // partner exactly at the limit, then one above it
    set_limit(16'd284);
    candidate_queue.push_back(16'd220);
    wait_drained();
    set_limit(16'd283);
    candidate_queue.push_back(16'd220);
    wait_drained();

    run_random(16'hFFFF, 20);
    run_random(16'd18416, 15);

    send_idle_pct <= 74;
    recv_idle_pct <= 35;
    @(posedge clk);
    run_random(FIELD_BITS'($urandom_range(1, 65535)), 15);
    run_random(16'd1210, 10);
    run_random(16'hFFFF, 10);

    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    set_limit(16'hFFFF);
    hold_go <= 1'b1;
    for (int k = 0; k < 8; k++)
      candidate_queue.push_back(FIELD_BITS'($urandom_range(2, 200)));
    wait_drained();
    run_random(16'hFFFF, 4);

    repeat (40) @(posedge clk);
    $display("checked %0d candidates under %0d search limits, %0d amicable pairs found",
             results_seen, limits_used, pairs_seen);
    $display("stalls on both channels plus one long result hold-off, %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
